/* design/tkc_pkg.sv */
// Token classifier package: token kinds, keyword table, result and push types,
// byte class helpers. No dependencies.
package tkc_pkg;

	typedef enum logic [2:0] {
		KIND_OPERATOR      = 3'd0,
		KIND_SEPARATOR     = 3'd1,
		KIND_KEYWORD       = 3'd2,
		KIND_IDENTIFIER    = 3'd3,
		KIND_UNKNOWN_TOKEN = 3'd4,
		KIND_UNKNOWN_CHAR  = 3'd5
	} kind_t;

	localparam int KW_NUM = 9;
	localparam logic [KW_NUM-1:0] KW_ALL = '1;

	// right-aligned text, first character in the highest used byte
	localparam logic [47:0] KW_TEXT [KW_NUM] = '{
		48'("for"), 48'("while"), 48'("if"), 48'("else"), 48'("return"),
		48'("int"), 48'("float"), 48'("char"), 48'("void")
	};
	localparam int unsigned KW_LEN [KW_NUM] = '{3, 5, 2, 4, 6, 3, 5, 4, 4};

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  symbol;
		logic [3:0]  keyword_index;
		logic [6:0]  word_length;
		logic        word_overflow;
		logic        last_of_run;
	} tkc_result_t;

	// up to two results per beat; v1 only with v0
	typedef struct packed {
		logic        v0;
		logic        v1;
		tkc_result_t r0;
		tkc_result_t r1;
	} tkc_push_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_word_char(input logic [7:0] c);
		return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7a)) ||
			((c >= 8'h41) && (c <= 8'h5a)) || (c == 8'h5f);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
	endfunction

	function automatic logic is_operator(input logic [7:0] c);
		return (c == "+") || (c == "-") || (c == "*") || (c == "/") ||
			(c == "%") || (c == "<") || (c == ">") || (c == "=") ||
			(c == "!") || (c == "&") || (c == "|") || (c == "^");
	endfunction

	function automatic logic is_separator(input logic [7:0] c);
		return (c == ",") || (c == ";") || (c == "(") || (c == ")") ||
			(c == "{") || (c == "}") || (c == "[") || (c == "]");
	endfunction

	// character of keyword k at position pos, zero past its end
	function automatic logic [7:0] kw_char(input int unsigned k, input logic [2:0] pos);
		int unsigned sh;
		logic [7:0]  ch;
		ch = '0;
		sh = 0;
		if (32'(pos) < KW_LEN[k]) begin
			sh = (KW_LEN[k] - 1 - 32'(pos)) * 8;
			ch = KW_TEXT[k][sh +: 8];
		end
		return ch;
	endfunction

endpackage

/* design/tkc_lexer.sv */
// Input register, open-word state and result generation for the token classifier.
// Depends on tkc_pkg.
module tkc_lexer import tkc_pkg::*; #(
	parameter int MAX_WORD_LENGTH = 127
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  logic [7:0] character,
	input  logic       end_of_line,
	input  logic       room,
	output tkc_push_t  push
);

	localparam int CNT_W = $clog2(MAX_WORD_LENGTH + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_WORD_LENGTH);

	logic              valid_s1;
	logic [7:0]        char_s1;
	logic              eol_s1;

	logic              in_word_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [KW_NUM-1:0] cand_q;
	logic              lead_q;
	logic              ovf_q;

	logic              adv;
	logic              wc, sp;
	logic [CNT_W-1:0]  cnt_e, cnt_n;
	logic [KW_NUM-1:0] cand_e, cand_n;
	logic              lead_e, ovf_e, ovf_n;
	logic              flush;
	tkc_result_t       word_r, char_r;

	function automatic tkc_result_t word_result(
		input logic [CNT_W-1:0]  cnt,
		input logic [KW_NUM-1:0] cand,
		input logic              lead,
		input logic              ovf
	);
		tkc_result_t      r;
		logic             hit;
		logic [CNT_W+6:0] ext;
		r = '0;
		r.kind = lead ? KIND_UNKNOWN_TOKEN : KIND_IDENTIFIER;
		hit = 1'b0;
		ext = {7'd0, cnt};
		// an overlong word never matches
		for (int k = 0; k < KW_NUM; k++) begin
			if (!hit && !ovf && cand[k] && (cnt == CNT_W'(KW_LEN[k]))) begin
				hit = 1'b1;
				r.kind = KIND_KEYWORD;
				r.keyword_index = 4'(k);
			end
		end
		r.word_length = ext[6:0];
		r.word_overflow = ovf;
		return r;
	endfunction

	assign adv       = valid_s1 && room;
	assign req_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_valid && req_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			char_s1 <= character;
			eol_s1  <= end_of_line;
		end
	end

	always_comb begin
		wc = is_word_char(char_s1);
		sp = is_space(char_s1);

		// a fresh word starts from the reset values
		cnt_e  = in_word_q ? cnt_q  : '0;
		cand_e = in_word_q ? cand_q : KW_ALL;
		lead_e = in_word_q ? lead_q : is_digit(char_s1);
		ovf_e  = in_word_q ? ovf_q  : 1'b0;

		for (int k = 0; k < KW_NUM; k++) begin
			cand_n[k] = cand_e[k] && (cnt_e < CNT_W'(KW_LEN[k])) &&
				(kw_char(k, cnt_e[2:0]) == char_s1);
		end
		if (cnt_e >= CNT_MAX) begin
			cnt_n = cnt_e;
			ovf_n = 1'b1;
		end else begin
			cnt_n = cnt_e + 1'b1;
			ovf_n = ovf_e;
		end

		char_r = '0;
		if (is_operator(char_s1)) begin
			char_r.kind = KIND_OPERATOR;
		end else if (is_separator(char_s1)) begin
			char_r.kind = KIND_SEPARATOR;
		end else begin
			char_r.kind = KIND_UNKNOWN_CHAR;
		end
		char_r.symbol = char_s1;

		push = '0;
		if (wc) begin
			word_r = word_result(cnt_n, cand_n, lead_e, ovf_n);
			flush  = eol_s1;
			push.v0 = adv && eol_s1;
			push.r0 = word_r;
			push.r0.last_of_run = 1'b1;
		end else begin
			word_r = word_result(cnt_q, cand_q, lead_q, ovf_q);
			flush  = in_word_q;
			if (in_word_q) begin
				push.v0 = adv;
				push.r0 = word_r;
				push.r0.last_of_run = sp;
				push.v1 = adv && !sp;
				push.r1 = char_r;
				push.r1.last_of_run = 1'b1;
			end else begin
				push.v0 = adv && !sp;
				push.r0 = char_r;
				push.r0.last_of_run = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_word_q <= 1'b0;
			cnt_q     <= '0;
			cand_q    <= KW_ALL;
			lead_q    <= 1'b0;
			ovf_q     <= 1'b0;
		end else if (adv) begin
			if (wc && !eol_s1) begin
				in_word_q <= 1'b1;
				cnt_q     <= cnt_n;
				cand_q    <= cand_n;
				lead_q    <= lead_e;
				ovf_q     <= ovf_n;
			end else if (wc || flush) begin
				in_word_q <= 1'b0;
				cnt_q     <= '0;
				cand_q    <= KW_ALL;
				lead_q    <= 1'b0;
				ovf_q     <= 1'b0;
			end
		end
	end

endmodule

/* design/tkc_result_queue.sv */
// Four-entry result queue for the token classifier: up to two pushes per cycle,
// one pop. Depends on tkc_pkg.
module tkc_result_queue import tkc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  tkc_push_t   push,
	output logic        room,
	output logic        head_valid,
	input  logic        head_ready,
	output tkc_result_t head
);

	tkc_result_t entry_q [4];
	logic [1:0]  wr_q, rd_q;
	logic [2:0]  cnt_q;
	logic        pop;

	assign room       = cnt_q <= 3'd2;
	assign head_valid = cnt_q != 3'd0;
	assign head       = entry_q[rd_q];
	assign pop        = head_valid && head_ready;

	always_ff @(posedge clk) begin
		if (push.v0) begin
			entry_q[wr_q] <= push.r0;
		end
		if (push.v1) begin
			entry_q[wr_q + 2'd1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + 2'(push.v0) + 2'(push.v1);
			rd_q  <= rd_q + 2'(pop);
			cnt_q <= cnt_q + 3'(push.v0) + 3'(push.v1) - 3'(pop);
		end
	end

endmodule

/* design/c_token_classifier_core.sv */
// Token classifier top level: one source byte per beat in, token results out.
// Each byte is held in the input register; its results go into the result queue, whose head drives the outputs.
// Throughput: one byte per cycle while tok_ready is held and each byte yields at most one result; a byte
// that closes a word and is itself a token yields two results.
// Input stalls when the four-entry result queue has fewer than two free slots.
// Reset (arst_n low, async): no word open, queue empty, input register empty.
module c_token_classifier_core import tkc_pkg::*; #(
	parameter int MAX_WORD_LENGTH = 127
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  logic [7:0] character,
	input  logic       end_of_line,
	output logic       tok_valid,
	input  logic       tok_ready,
	output logic [2:0] kind,
	output logic [7:0] symbol,
	output logic [3:0] keyword_index,
	output logic [6:0] word_length,
	output logic       word_overflow,
	output logic       last_of_run
);

	tkc_push_t   push;
	logic        room;
	tkc_result_t head;

	tkc_lexer #(
		.MAX_WORD_LENGTH(MAX_WORD_LENGTH)
	) u_lexer (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.character   (character),
		.end_of_line (end_of_line),
		.room        (room),
		.push        (push)
	);

	tkc_result_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.room       (room),
		.head_valid (tok_valid),
		.head_ready (tok_ready),
		.head       (head)
	);

	assign kind          = head.kind;
	assign symbol        = head.symbol;
	assign keyword_index = head.keyword_index;
	assign word_length   = head.word_length;
	assign word_overflow = head.word_overflow;
	assign last_of_run   = head.last_of_run;

	// second result only ever follows a first in the same beat
	assert property (@(posedge clk) disable iff (!arst_n) push.v1 |-> push.v0)
		else $error("second result pushed without first");

	// never push into a queue without two free slots
	assert property (@(posedge clk) disable iff (!arst_n) push.v0 |-> room)
		else $error("result pushed into full queue");

	// a keyword is never an overlong word and carries no symbol
	assert property (@(posedge clk) disable iff (!arst_n)
		(tok_valid && (kind == KIND_KEYWORD)) |-> (!word_overflow && (symbol == 8'd0)))
		else $error("malformed keyword result");

endmodule
